FILE: hw/rtl/tcpq_pkg.sv
`default_nettype none
package tcpq_pkg;

    localparam int CLASS_DEPTH = 16;
    localparam int NUM_CLASSES = 3;
    localparam int MEM_DEPTH   = NUM_CLASSES * CLASS_DEPTH;
    localparam int PTR_W       = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int CLS_W       = 2;
    localparam int CMD_W       = 2;
    localparam int ID_W        = 32;
    localparam int AGE_W       = 8;
    localparam int TOT_W       = 6;
    localparam int ENTRY_W     = ID_W + AGE_W + 1;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 56;

    localparam logic [AGE_W-1:0] ELDER_THR_RST = 8'd65;

    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    localparam logic [CLS_W-1:0] CLS_FLAG   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_ELDER  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_NORMAL = 2'd2;

    typedef struct packed {
        logic accept;
        logic load;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [CLS_W-1:0] c,
                                                   input logic [PTR_W-1:0] p);
        return ADDR_W'(c) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(p);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tcpq_ctrl.sv
`default_nettype none
module tcpq_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire tcpq_pkg::t_dp_status  i_sts,
    output tcpq_pkg::t_ctl_cmd         o_ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RESP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_ctl.accept = 1'b0;
        o_ctl.load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tcpq_datapath.sv
`default_nettype none
module tcpq_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tcpq_pkg::t_ctl_cmd            i_ctl,
    output tcpq_pkg::t_dp_status               o_sts,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [tcpq_pkg::AGE_W-1:0]    i_cfg_wr_data,
    input  wire logic [tcpq_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [tcpq_pkg::ID_W-1:0]     i_item_id,
    input  wire logic [tcpq_pkg::AGE_W-1:0]    i_item_age,
    input  wire logic                          i_priority_flag,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_ok,
    output logic [tcpq_pkg::ID_W-1:0]          o_head_id,
    output logic [tcpq_pkg::AGE_W-1:0]         o_head_age,
    output logic                               o_head_flag,
    output logic [tcpq_pkg::CLS_W-1:0]         o_head_class,
    output logic [tcpq_pkg::TOT_W-1:0]         o_total_count
);

    localparam int NC = tcpq_pkg::NUM_CLASSES;

    logic [tcpq_pkg::AGE_W-1:0]   r_thr;
    logic [tcpq_pkg::PTR_W-1:0]   r_head [NC];
    logic [tcpq_pkg::PTR_W-1:0]   r_tail [NC];
    logic [tcpq_pkg::CNT_W-1:0]   r_cnt  [NC];
    logic [tcpq_pkg::PTR_W-1:0]   n_head [NC];
    logic [tcpq_pkg::PTR_W-1:0]   n_tail [NC];
    logic [tcpq_pkg::CNT_W-1:0]   n_cnt  [NC];
    logic [tcpq_pkg::TOT_W-1:0]   r_total;
    logic [tcpq_pkg::TOT_W-1:0]   n_total;

    logic [tcpq_pkg::ENTRY_W-1:0] mem [tcpq_pkg::MEM_DEPTH];
    logic [tcpq_pkg::ENTRY_W-1:0] r_rd_data;

    logic                         r_pend_ok;
    logic                         r_pend_mem;
    logic [tcpq_pkg::CLS_W-1:0]   r_pend_class;
    logic                         n_pend_ok;
    logic                         n_pend_mem;
    logic [tcpq_pkg::CLS_W-1:0]   n_pend_class;

    logic                         r_out_valid;
    logic                         r_out_ok;
    logic [tcpq_pkg::ENTRY_W-1:0] r_out_entry;
    logic [tcpq_pkg::CLS_W-1:0]   r_out_class;
    logic [tcpq_pkg::TOT_W-1:0]   r_out_total;

    logic [tcpq_pkg::CLS_W-1:0]   enq_cls;
    logic [tcpq_pkg::CLS_W-1:0]   deq_cls;
    logic                         any_held;
    logic                         enq_room;
    logic                         we;
    logic                         re;
    logic [tcpq_pkg::ADDR_W-1:0]  waddr;
    logic [tcpq_pkg::ADDR_W-1:0]  raddr;

    // classification and head selection
    always_comb begin
        if (i_priority_flag) begin
            enq_cls = tcpq_pkg::CLS_FLAG;
        end else if (i_item_age >= r_thr) begin
            enq_cls = tcpq_pkg::CLS_ELDER;
        end else begin
            enq_cls = tcpq_pkg::CLS_NORMAL;
        end
        if (r_cnt[0] != '0) begin
            deq_cls = tcpq_pkg::CLS_FLAG;
        end else if (r_cnt[1] != '0) begin
            deq_cls = tcpq_pkg::CLS_ELDER;
        end else begin
            deq_cls = tcpq_pkg::CLS_NORMAL;
        end
        any_held = (r_cnt[0] != '0) || (r_cnt[1] != '0) || (r_cnt[2] != '0);
        enq_room = r_cnt[enq_cls] < tcpq_pkg::CNT_W'(tcpq_pkg::CLASS_DEPTH);
        waddr    = tcpq_pkg::mem_addr(enq_cls, r_tail[enq_cls]);
        raddr    = tcpq_pkg::mem_addr(deq_cls, r_head[deq_cls]);
    end

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_cnt        = r_cnt;
        n_total      = r_total;
        n_pend_ok    = r_pend_ok;
        n_pend_mem   = r_pend_mem;
        n_pend_class = r_pend_class;
        we           = 1'b0;
        re           = 1'b0;
        if (i_ctl.accept) begin
            n_pend_ok    = 1'b0;
            n_pend_mem   = 1'b0;
            n_pend_class = tcpq_pkg::CLS_FLAG;
            case (i_cmd)
                tcpq_pkg::CMD_ENQ: begin
                    n_pend_class = enq_cls;
                    if (enq_room) begin
                        we              = 1'b1;
                        n_pend_ok       = 1'b1;
                        n_tail[enq_cls] = tcpq_pkg::ptr_advance(r_tail[enq_cls]);
                        n_cnt[enq_cls]  = r_cnt[enq_cls] + tcpq_pkg::CNT_W'(1);
                        n_total         = r_total + tcpq_pkg::TOT_W'(1);
                    end
                end
                tcpq_pkg::CMD_DEQ, tcpq_pkg::CMD_PEEK: begin
                    if (any_held) begin
                        re           = 1'b1;
                        n_pend_ok    = 1'b1;
                        n_pend_mem   = 1'b1;
                        n_pend_class = deq_cls;
                        if (i_cmd == tcpq_pkg::CMD_DEQ) begin
                            n_head[deq_cls] = tcpq_pkg::ptr_advance(r_head[deq_cls]);
                            n_cnt[deq_cls]  = r_cnt[deq_cls] - tcpq_pkg::CNT_W'(1);
                            n_total         = r_total - tcpq_pkg::TOT_W'(1);
                        end
                    end
                end
                default: begin
                    n_pend_ok = 1'b0;
                end
            endcase
        end
    end

    // entry store
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= {i_priority_flag, i_item_age, i_item_id};
        end
        if (re) begin
            r_rd_data <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= tcpq_pkg::ELDER_THR_RST;
            r_total <= '0;
            for (int k = 0; k < NC; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_ok    <= n_pend_ok;
        r_pend_mem   <= n_pend_mem;
        r_pend_class <= n_pend_class;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_out_ok    <= r_pend_ok;
            r_out_entry <= r_pend_mem ? r_rd_data : '0;
            r_out_class <= r_pend_class;
            r_out_total <= r_total;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_out_ok;
    assign o_head_id      = r_out_entry[tcpq_pkg::ID_W-1:0];
    assign o_head_age     = r_out_entry[tcpq_pkg::ID_W +: tcpq_pkg::AGE_W];
    assign o_head_flag    = r_out_entry[tcpq_pkg::ENTRY_W-1];
    assign o_head_class   = r_out_class;
    assign o_total_count  = r_out_total;

endmodule
`default_nettype wire

FILE: hw/rtl/three_class_priority_queue.sv
// an accepted item's result goes to the pending registers and the entry store read
// register, then to the output register; a new item is taken only after that load
// a result held in the output register stalls the load of the following item's result
// reset: synchronous, active low; clears pointers, counts and output valid,
// loads the elder age threshold with 65; entry store contents are not cleared
`default_nettype none
module three_class_priority_queue (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [tcpq_pkg::AGE_W-1:0]        i_cfg_wr_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // item_id, item_age, priority_flag, zero pad
    input  wire logic [tcpq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // cmd
    input  wire logic [tcpq_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // ok, head_id, head_age, head_flag, head_class, total_count, zero pad
    output logic [tcpq_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

    tcpq_pkg::t_ctl_cmd   ctl;
    tcpq_pkg::t_dp_status sts;

    logic                         ok;
    logic [tcpq_pkg::ID_W-1:0]    head_id;
    logic [tcpq_pkg::AGE_W-1:0]   head_age;
    logic                         head_flag;
    logic [tcpq_pkg::CLS_W-1:0]   head_class;
    logic [tcpq_pkg::TOT_W-1:0]   total_count;

    tcpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    tcpq_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (s_axis_tuser),
        .i_item_id       (s_axis_tdata[31:0]),
        .i_item_age      (s_axis_tdata[39:32]),
        .i_priority_flag (s_axis_tdata[40]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_ok            (ok),
        .o_head_id       (head_id),
        .o_head_age      (head_age),
        .o_head_flag     (head_flag),
        .o_head_class    (head_class),
        .o_total_count   (total_count)
    );

    assign m_axis_tdata = {6'd0, total_count, head_class, head_flag, head_age, head_id, ok};

endmodule
`default_nettype wire

FILE: hw/rtl/tcpq_checker.sv
`default_nettype none
module tcpq_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [tcpq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one item in flight at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous one in work");

    // failed operation reports no head payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[41:1] == 41'd0)
        else $error("failed operation carries head data");

    // a flagged head always comes from the flagged class
    a_flag_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[41] |->
            m_axis_tdata[43:42] == tcpq_pkg::CLS_FLAG)
        else $error("flagged head reported in wrong class");

endmodule

bind three_class_priority_queue tcpq_checker u_tcpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: dv/tb_three_class_priority_queue.sv
`default_nettype none
module tb_three_class_priority_queue;
    import tcpq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 80;

    // reply field offsets in m_axis_tdata
    localparam int OFS_ID    = 1;
    localparam int OFS_AGE   = OFS_ID + ID_W;
    localparam int OFS_FLAG  = OFS_AGE + AGE_W;
    localparam int OFS_CLS   = OFS_FLAG + 1;
    localparam int OFS_TOTAL = OFS_CLS + CLS_W;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
        logic             flag;
    } t_slot;

    typedef struct packed {
        logic             ok;
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
        logic             flag;
        logic [CLS_W-1:0] cls;
        logic [TOT_W-1:0] total;
    } t_reply;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
        logic             flag;
        bit               typed;
        t_reply           want;
    } t_dir_row;

    localparam t_reply NO_REPLY = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [AGE_W-1:0]      i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    wire logic             s_axis_tready;
    // item_id, item_age, priority_flag, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // cmd
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    wire logic             m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // ok, head_id, head_age, head_flag, head_class, total_count, zero pad
    wire logic [OUT_DATA_W-1:0] m_axis_tdata;

    three_class_priority_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // queue model state
    t_slot            class_fifo [NUM_CLASSES][CLASS_DEPTH];
    int unsigned      rd_ptr [NUM_CLASSES] = '{0, 0, 0};
    int unsigned      wr_ptr [NUM_CLASSES] = '{0, 0, 0};
    int unsigned      held   [NUM_CLASSES] = '{0, 0, 0};
    logic [AGE_W-1:0] elder_thr = ELDER_THR_RST;

    t_reply   pending_replies [$];
    t_dir_row dir_rows [$];
    bit       calm = 1'b0;
    int       ready_hold = 0;
    int       mismatches = 0;
    int       items_sent = 0;
    int       replies_checked = 0;
    int       full_rejects = 0;
    int       empty_reads = 0;
    int       cycle_count = 0;

    function automatic int unsigned total_held();
        return held[0] + held[1] + held[2];
    endfunction

    function automatic t_reply serve_request(input logic [CMD_W-1:0] cmd,
                                             input logic [ID_W-1:0] id,
                                             input logic [AGE_W-1:0] age,
                                             input logic flag);
        t_reply r;
        int     c;
        r = '0;
        if (cmd == CMD_ENQ) begin
            if (flag)
                c = int'(CLS_FLAG);
            else if (age >= elder_thr)
                c = int'(CLS_ELDER);
            else
                c = int'(CLS_NORMAL);
            r.cls = CLS_W'(c);
            if (held[c] < CLASS_DEPTH) begin
                class_fifo[c][wr_ptr[c]] = '{id: id, age: age, flag: flag};
                wr_ptr[c] = (wr_ptr[c] + 1) % CLASS_DEPTH;
                held[c]++;
                r.ok = 1'b1;
            end else begin
                full_rejects++;
            end
        end else if (cmd == CMD_DEQ || cmd == CMD_PEEK) begin
            c = 0;
            while (c < NUM_CLASSES && held[c] == 0)
                c++;
            if (c < NUM_CLASSES) begin
                r.ok   = 1'b1;
                r.id   = class_fifo[c][rd_ptr[c]].id;
                r.age  = class_fifo[c][rd_ptr[c]].age;
                r.flag = class_fifo[c][rd_ptr[c]].flag;
                r.cls  = CLS_W'(c);
                if (cmd == CMD_DEQ) begin
                    rd_ptr[c] = (rd_ptr[c] + 1) % CLASS_DEPTH;
                    held[c]--;
                end
            end else begin
                empty_reads++;
            end
        end
        r.total = TOT_W'(total_held());
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_error($sformatf("reply %0d %s got %0h want %0h",
                                 replies_checked, name, got, want));
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [AGE_W-1:0] age, input logic flag,
                           input bit typed, input t_reply want);
        t_dir_row row;
        row.cmd   = cmd;
        row.id    = id;
        row.age   = age;
        row.flag  = flag;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [AGE_W-1:0] age, input logic flag,
                             input bit typed, input t_reply want);
        t_reply predicted;
        if (!calm && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_DATA_W'({flag, age, id});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted = serve_request(cmd, id, age, flag);
        pending_replies.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_elder_threshold(input logic [AGE_W-1:0] thr);
        wait_idle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= thr;
        elder_thr = thr;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int n_items);
        bit               filling;
        int               mode_left;
        int               w;
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
        filling   = 1'b1;
        mode_left = $urandom_range(20, 60);
        repeat (n_items) begin
            w = $urandom_range(0, 99);
            if (filling)
                cmd = (w < 72) ? CMD_ENQ : (w < 86) ? CMD_DEQ : (w < 97) ? CMD_PEEK : CMD_BAD;
            else
                cmd = (w < 18) ? CMD_ENQ : (w < 78) ? CMD_DEQ : (w < 97) ? CMD_PEEK : CMD_BAD;
            case ($urandom_range(0, 15))
                0: id = '0;
                1: id = '1;
                default: id = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0: age = elder_thr;
                1: age = elder_thr - 8'd1;
                2: age = elder_thr + 8'd1;
                3: age = '0;
                4: age = '1;
                default: age = AGE_W'($urandom_range(0, 255));
            endcase
            send_item(cmd, id, age, $urandom_range(0, 3) == 0, 1'b0, NO_REPLY);
            mode_left--;
            if (mode_left <= 0 || (!filling && total_held() == 0)) begin
                filling   = !filling;
                mode_left = $urandom_range(10, 50);
            end
        end
    endtask

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            ready_hold = int'($urandom_range(0, 15));
        end
    end

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ok    = m_axis_tdata[0];
            got.id    = m_axis_tdata[OFS_ID +: ID_W];
            got.age   = m_axis_tdata[OFS_AGE +: AGE_W];
            got.flag  = m_axis_tdata[OFS_FLAG];
            got.cls   = m_axis_tdata[OFS_CLS +: CLS_W];
            got.total = m_axis_tdata[OFS_TOTAL +: TOT_W];
            if (pending_replies.size() == 0) begin
                flag_error($sformatf("reply with nothing pending: %0h", m_axis_tdata));
            end else begin
                want = pending_replies.pop_front();
                check_field("ok", 64'(got.ok), 64'(want.ok));
                check_field("head_id", 64'(got.id), 64'(want.id));
                check_field("head_age", 64'(got.age), 64'(want.age));
                check_field("head_flag", 64'(got.flag), 64'(want.flag));
                check_field("head_class", 64'(got.cls), 64'(want.cls));
                check_field("total_count", 64'(got.total), 64'(want.total));
                replies_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies pending", cycle_count,
                     pending_replies.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [ID_W-1:0]  rid;
        logic [AGE_W-1:0] thr;
        rid = $urandom;
        // threshold at its reset value for the whole table
        add_row(CMD_DEQ, '0, '0, 1'b0, 1'b1,
                t_reply'{1'b0, 32'h0, 8'h0, 1'b0, 2'b00, 6'd0});
        add_row(CMD_PEEK, '0, '0, 1'b0, 1'b1,
                t_reply'{1'b0, 32'h0, 8'h0, 1'b0, 2'b00, 6'd0});
        add_row(CMD_BAD, '1, '1, 1'b1, 1'b1,
                t_reply'{1'b0, 32'h0, 8'h0, 1'b0, 2'b00, 6'd0});
        add_row(CMD_ENQ, '1, '1, 1'b1, 1'b1,
                t_reply'{1'b1, 32'h0, 8'h0, 1'b0, CLS_FLAG, 6'd1});
        add_row(CMD_ENQ, '0, '0, 1'b0, 1'b1,
                t_reply'{1'b1, 32'h0, 8'h0, 1'b0, CLS_NORMAL, 6'd2});
        add_row(CMD_ENQ, rid, 8'd65, 1'b0, 1'b0, NO_REPLY);
        add_row(CMD_ENQ, 32'h1234_5678, 8'd64, 1'b0, 1'b1,
                t_reply'{1'b1, 32'h0, 8'h0, 1'b0, CLS_NORMAL, 6'd4});
        add_row(CMD_BAD, 32'h5555_AAAA, 8'h0F, 1'b0, 1'b1,
                t_reply'{1'b0, 32'h0, 8'h0, 1'b0, 2'b00, 6'd4});
        add_row(CMD_PEEK, '0, '0, 1'b0, 1'b1,
                t_reply'{1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1, CLS_FLAG, 6'd4});
        add_row(CMD_DEQ, '0, '0, 1'b0, 1'b1,
                t_reply'{1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1, CLS_FLAG, 6'd3});
        add_row(CMD_PEEK, '1, '1, 1'b1, 1'b0, NO_REPLY);
        add_row(CMD_DEQ, '0, '0, 1'b0, 1'b0, NO_REPLY);
        add_row(CMD_DEQ, '0, '0, 1'b0, 1'b1,
                t_reply'{1'b1, 32'h0, 8'h0, 1'b0, CLS_NORMAL, 6'd1});
        add_row(CMD_ENQ, 32'hAAAA_5555, 8'h00, 1'b1, 1'b1,
                t_reply'{1'b1, 32'h0, 8'h0, 1'b0, CLS_FLAG, 6'd2});
        add_row(CMD_DEQ, '0, '0, 1'b0, 1'b1,
                t_reply'{1'b1, 32'hAAAA_5555, 8'h00, 1'b1, CLS_FLAG, 6'd1});
        add_row(CMD_DEQ, '0, '0, 1'b0, 1'b1,
                t_reply'{1'b1, 32'h1234_5678, 8'd64, 1'b0, CLS_NORMAL, 6'd0});
        add_row(CMD_DEQ, '0, '0, 1'b0, 1'b1,
                t_reply'{1'b0, 32'h0, 8'h0, 1'b0, 2'b00, 6'd0});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].age, dir_rows[i].flag,
                      dir_rows[i].typed, dir_rows[i].want);

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: thr = 8'd0;
                1: thr = 8'd255;
                2: thr = ELDER_THR_RST;
                default: thr = AGE_W'($urandom_range(0, 255));
            endcase
            // no idling on either side in the last phase
            if (p == RAND_PHASES - 1)
                calm = 1'b1;
            set_elder_threshold(thr);
            run_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("ran %0d items over %0d threshold settings, %0d replies checked",
                 items_sent, RAND_PHASES + 1, replies_checked);
        $display("saw %0d enqueues into a full class and %0d reads of an empty queue",
                 full_rejects, empty_reads);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire
